>>> hw/rtl/dsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual stepper scheduler package
// Shared widths, command codes and the result record of the load sequencer.
// ----------------------------------------------------------------------------
package dsps_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CNT_IDX_W   = $clog2(COUNT_WIDTH);
	localparam int ARM_RESET   = 100;
	localparam int FIELD_W     = 16;
	localparam int S_DATA_W    = 40;
	localparam int M_DATA_W    = 40;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [COUNT_WIDTH:0]   wide_t;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_LIMIT_A = 2'd2,
		CMD_LIMIT_B = 2'd3
	} cmd_t;

	typedef struct packed {
		logic   done;
		count_t period_a;
		count_t period_b;
	} seq_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/dual_stepper_pulse_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual stepper pulse scheduler
// Schedules step pulses for two motors so that both finish a move together.
//
// Commands arrive on the s_ stream, one transfer per command, with the
// command code on s_tuser. Every command yields exactly one result transfer
// on the m_ stream carrying both pulse flags, direction pins and the pending
// step counts after the command.
// For tick and limit-switch commands the result is registered the cycle
// after the input transfer. A load command runs a binary GCD and two
// restoring divisions of COUNT_WIDTH steps each through one shared
// subtractor; a zero step count skips the GCD and the divisions.
// s_tready is low while a load is in progress and while a result waits in
// the output register and m_tready is low, so a stalled receiver stalls the
// command stream without losing or repeating any result.
// After reset the counts and periods are zero, the countdowns are 100, the
// motors are disarmed and both headings are clockwise.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_scheduler (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// load_steps_a, load_steps_b, load_dir_a, load_dir_b, zero fill
	input  wire [dsps_pkg::S_DATA_W-1:0]   s_tdata,
	// command
	input  wire [1:0]                      s_tuser,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// pulse_a, pulse_b, dir_pin_a, dir_pin_b, left_count_a, left_count_b, zero fill
	output logic [dsps_pkg::M_DATA_W-1:0]  m_tdata
);

	localparam int FW = dsps_pkg::FIELD_W;

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} state_t;

	state_t             state_q;
	dsps_pkg::count_t   left_a_q, left_b_q, cd_a_q, cd_b_q, per_a_q, per_b_q;
	logic               armed_a_q, armed_b_q, head_a_q, head_b_q;
	logic               m_valid_q, pulse_a_q, pulse_b_q;
	dsps_pkg::seq_res_t seq_res;

	dsps_pkg::cmd_t     cmd;
	dsps_pkg::count_t   in_sa, in_sb;
	logic               accept, start;

	dsps_pkg::count_t   cd_a_dec, cd_b_dec;
	logic               fire_a, fire_b;

	assign cmd      = dsps_pkg::cmd_t'(s_tuser);
	assign in_sa    = dsps_pkg::count_t'(s_tdata[FW-1:0]);
	assign in_sb    = dsps_pkg::count_t'(s_tdata[2*FW-1:FW]);
	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign start    = accept && (cmd == dsps_pkg::CMD_LOAD);

	assign cd_a_dec = cd_a_q - 1'b1;
	assign cd_b_dec = cd_b_q - 1'b1;
	assign fire_a   = (left_a_q != '0) && armed_a_q;
	assign fire_b   = (left_b_q != '0) && armed_b_q;

	dsps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sa     (in_sa),
		.sb     (in_sb),
		.res    (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			left_a_q  <= '0;
			left_b_q  <= '0;
			cd_a_q    <= dsps_pkg::count_t'(dsps_pkg::ARM_RESET);
			cd_b_q    <= dsps_pkg::count_t'(dsps_pkg::ARM_RESET);
			per_a_q   <= '0;
			per_b_q   <= '0;
			armed_a_q <= 1'b0;
			armed_b_q <= 1'b0;
			head_a_q  <= 1'b1;
			head_b_q  <= 1'b1;
			m_valid_q <= 1'b0;
			pulse_a_q <= 1'b0;
			pulse_b_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pulse_a_q <= 1'b0;
						pulse_b_q <= 1'b0;
						unique case (cmd)
							dsps_pkg::CMD_TICK: begin
								m_valid_q <= 1'b1;
								pulse_a_q <= fire_a;
								pulse_b_q <= fire_b;
								if (fire_a) begin
									left_a_q <= left_a_q - 1'b1;
								end
								if (fire_b) begin
									left_b_q <= left_b_q - 1'b1;
								end
								if (cd_a_dec == '0) begin
									cd_a_q    <= per_a_q;
									armed_a_q <= 1'b1;
								end else begin
									cd_a_q    <= cd_a_dec;
									armed_a_q <= armed_a_q && !fire_a;
								end
								if (cd_b_dec == '0) begin
									cd_b_q    <= per_b_q;
									armed_b_q <= 1'b1;
								end else begin
									cd_b_q    <= cd_b_dec;
									armed_b_q <= armed_b_q && !fire_b;
								end
							end
							dsps_pkg::CMD_LOAD: begin
								left_a_q <= in_sa;
								left_b_q <= in_sb;
								head_a_q <= s_tdata[2*FW];
								head_b_q <= s_tdata[2*FW+1];
								state_q  <= ST_LOAD;
							end
							dsps_pkg::CMD_LIMIT_A: begin
								left_a_q  <= '0;
								m_valid_q <= 1'b1;
							end
							dsps_pkg::CMD_LIMIT_B: begin
								left_b_q  <= '0;
								m_valid_q <= 1'b1;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOAD: begin
					if (seq_res.done) begin
						per_a_q   <= seq_res.period_a;
						per_b_q   <= seq_res.period_b;
						cd_a_q    <= dsps_pkg::count_t'(1);
						cd_b_q    <= dsps_pkg::count_t'(1);
						armed_a_q <= 1'b0;
						armed_b_q <= 1'b0;
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, FW'(left_b_q), FW'(left_a_q), head_b_q, head_a_q,
		pulse_b_q, pulse_a_q};

endmodule
`default_nettype wire

>>> hw/rtl/dsps_sub.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared subtractor
// One subtract and compare unit used by the GCD and division steps of the load sequencer.
// ----------------------------------------------------------------------------
module dsps_sub (
	input  wire dsps_pkg::wide_t a,
	input  wire dsps_pkg::wide_t b,
	output dsps_pkg::wide_t      diff,
	output logic                 borrow,
	output logic                 zero
);

	logic [dsps_pkg::COUNT_WIDTH+1:0] full;

	assign full   = {1'b0, a} - {1'b0, b};
	assign diff   = full[dsps_pkg::COUNT_WIDTH:0];
	assign borrow = full[dsps_pkg::COUNT_WIDTH+1];
	assign zero   = (diff == '0);

endmodule
`default_nettype wire

>>> hw/rtl/dsps_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Load sequencer
// Binary GCD of the two step counts followed by two restoring divisions,
// all driven through the shared subtractor.
// ----------------------------------------------------------------------------
module dsps_seq (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire dsps_pkg::count_t sa,
	input  wire dsps_pkg::count_t sb,
	output dsps_pkg::seq_res_t    res
);

	localparam int CW = dsps_pkg::COUNT_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_SHL,
		S_DIVA,
		S_DIVB
	} state_t;

	state_t                            state_q;
	dsps_pkg::count_t                  x_q, y_q, g_q, sa_q, sb_q, rem_q, quo_q;
	logic [dsps_pkg::CNT_IDX_W-1:0]    k_q, bit_q;
	dsps_pkg::seq_res_t                res_q;

	dsps_pkg::wide_t op_a, op_b, diff;
	logic            borrow, zero, qbit;
	dsps_pkg::count_t quo_n;

	always_comb begin
		if (state_q == S_GCD) begin
			op_a = {1'b0, x_q};
			op_b = {1'b0, y_q};
		end else begin
			op_a = {rem_q, quo_q[CW-1]};
			op_b = {1'b0, g_q};
		end
	end

	dsps_sub u_sub (
		.a      (op_a),
		.b      (op_b),
		.diff   (diff),
		.borrow (borrow),
		.zero   (zero)
	);

	assign qbit  = ~borrow;
	assign quo_n = {quo_q[CW-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			g_q     <= '0;
			sa_q    <= '0;
			sb_q    <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			k_q     <= '0;
			bit_q   <= '0;
			res_q   <= '0;
		end else begin
			res_q.done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sa_q <= sa;
						sb_q <= sb;
						x_q  <= sa;
						y_q  <= sb;
						k_q  <= '0;
						if (sa == '0 || sb == '0) begin
							res_q.period_a <= dsps_pkg::count_t'(1);
							res_q.period_b <= dsps_pkg::count_t'(1);
							res_q.done     <= 1'b1;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					priority if (zero) begin
						g_q     <= x_q;
						state_q <= S_SHL;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (!borrow) begin
						x_q <= diff[CW-1:0];
					end else begin
						x_q <= y_q;
						y_q <= x_q;
					end
				end
				S_SHL: begin
					if (k_q != '0) begin
						g_q <= g_q << 1;
						k_q <= k_q - 1'b1;
					end else begin
						rem_q   <= '0;
						quo_q   <= sb_q;
						bit_q   <= dsps_pkg::CNT_IDX_W'(CW - 1);
						state_q <= S_DIVA;
					end
				end
				S_DIVA, S_DIVB: begin
					rem_q <= qbit ? diff[CW-1:0] : op_a[CW-1:0];
					quo_q <= quo_n;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						rem_q <= '0;
						bit_q <= dsps_pkg::CNT_IDX_W'(CW - 1);
						if (state_q == S_DIVA) begin
							res_q.period_a <= quo_n;
							quo_q          <= sa_q;
							state_q        <= S_DIVB;
						end else begin
							res_q.period_b <= quo_n;
							res_q.done     <= 1'b1;
							state_q        <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

>>> verif/pulse_schedule_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse schedule monitor
// Watches both streams of the dual stepper pulse scheduler. Every accepted
// command runs through a cycle-free model of the two motor channels, and the
// expected result is queued. Every result transfer is compared field by field
// with the oldest queued result. Mismatch and queue counts go to the top.
// ----------------------------------------------------------------------------
module pulse_schedule_monitor (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	input  wire                            s_tready,
	// load_steps_a, load_steps_b, load_dir_a, load_dir_b, zero fill
	input  wire [dsps_pkg::S_DATA_W-1:0]   s_tdata,
	// command
	input  wire [1:0]                      s_tuser,
	input  wire                            m_tvalid,
	input  wire                            m_tready,
	// pulse_a, pulse_b, dir_pin_a, dir_pin_b, left_count_a, left_count_b, zero fill
	input  wire [dsps_pkg::M_DATA_W-1:0]   m_tdata,
	output int                             mismatches,
	output int                             outstanding
);

	typedef struct packed {
		logic [dsps_pkg::FIELD_W-1:0] steps_b;
		logic [dsps_pkg::FIELD_W-1:0] steps_a;
	} step_pair_t;

	typedef struct packed {
		logic               dir_b;
		logic               dir_a;
		step_pair_t         steps;
	} move_order_t;

	typedef struct packed {
		logic [dsps_pkg::FIELD_W-1:0] left_b;
		logic [dsps_pkg::FIELD_W-1:0] left_a;
		logic                         dir_b;
		logic                         dir_a;
		logic                         pulse_b;
		logic                         pulse_a;
	} step_report_t;

	dsps_pkg::count_t remaining [2];
	dsps_pkg::count_t countdown [2];
	dsps_pkg::count_t interval  [2];
	logic             armed     [2];
	logic             heading   [2];
	step_report_t     expected_reports [$];

	task automatic advance_motors(input dsps_pkg::cmd_t cmd, input move_order_t order,
			output step_report_t rep);
		dsps_pkg::count_t x;
		dsps_pkg::count_t y;
		dsps_pkg::count_t r;
		logic [1:0]       pulse;
		pulse = '0;
		case (cmd)
			dsps_pkg::CMD_TICK: begin
				for (int i = 0; i < 2; i++) begin
					countdown[i] = countdown[i] - 1'b1;
					if (remaining[i] != '0 && armed[i]) begin
						pulse[i]     = 1'b1;
						remaining[i] = remaining[i] - 1'b1;
						armed[i]     = 1'b0;
					end
					if (countdown[i] == '0) begin
						countdown[i] = interval[i];
						armed[i]     = 1'b1;
					end
				end
			end
			dsps_pkg::CMD_LOAD: begin
				x = dsps_pkg::count_t'(order.steps.steps_a);
				y = dsps_pkg::count_t'(order.steps.steps_b);
				if (x == '0 || y == '0) begin
					interval[0] = dsps_pkg::count_t'(1);
					interval[1] = dsps_pkg::count_t'(1);
				end else begin
					while (y != '0) begin
						r = x % y;
						x = y;
						y = r;
					end
					interval[0] = dsps_pkg::count_t'(order.steps.steps_b) / x;
					interval[1] = dsps_pkg::count_t'(order.steps.steps_a) / x;
				end
				remaining[0] = dsps_pkg::count_t'(order.steps.steps_a);
				remaining[1] = dsps_pkg::count_t'(order.steps.steps_b);
				heading[0]   = order.dir_a;
				heading[1]   = order.dir_b;
				armed[0]     = 1'b0;
				armed[1]     = 1'b0;
				countdown[0] = dsps_pkg::count_t'(1);
				countdown[1] = dsps_pkg::count_t'(1);
			end
			dsps_pkg::CMD_LIMIT_A: begin
				remaining[0] = '0;
			end
			default: begin
				remaining[1] = '0;
			end
		endcase
		rep.pulse_a = pulse[0];
		rep.pulse_b = pulse[1];
		rep.dir_a   = heading[0];
		rep.dir_b   = heading[1];
		rep.left_a  = dsps_pkg::FIELD_W'(remaining[0]);
		rep.left_b  = dsps_pkg::FIELD_W'(remaining[1]);
	endtask

	task automatic check_field(input string name,
			input logic [dsps_pkg::FIELD_W-1:0] want,
			input logic [dsps_pkg::FIELD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		step_report_t want;
		step_report_t got;
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				remaining[i] = '0;
				countdown[i] = dsps_pkg::count_t'(dsps_pkg::ARM_RESET);
				interval[i]  = '0;
				armed[i]     = 1'b0;
				heading[i]   = 1'b1;
			end
			expected_reports.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_motors(dsps_pkg::cmd_t'(s_tuser),
					s_tdata[$bits(move_order_t)-1:0], want);
				expected_reports.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(step_report_t)-1:0];
				if (expected_reports.size() == 0) begin
					$error("result transfer with no command outstanding");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("pulse_a", dsps_pkg::FIELD_W'(want.pulse_a),
						dsps_pkg::FIELD_W'(got.pulse_a));
					check_field("pulse_b", dsps_pkg::FIELD_W'(want.pulse_b),
						dsps_pkg::FIELD_W'(got.pulse_b));
					check_field("dir_pin_a", dsps_pkg::FIELD_W'(want.dir_a),
						dsps_pkg::FIELD_W'(got.dir_a));
					check_field("dir_pin_b", dsps_pkg::FIELD_W'(want.dir_b),
						dsps_pkg::FIELD_W'(got.dir_b));
					check_field("left_count_a", want.left_a, got.left_a);
					check_field("left_count_b", want.left_b, got.left_b);
				end
			end
			outstanding = expected_reports.size();
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stepper pulse scheduler testbench
// Drives tick, load and limit-switch commands: a directed set of corner
// cases, then random moves with random tick runs, under three idle patterns
// on the command and result streams. The monitor predicts and checks every
// result; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 170;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic [dsps_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic [1:0]                    s_tuser  = dsps_pkg::CMD_TICK;
	logic                          m_tready = 1'b0;
	wire                           s_tready;
	wire                           m_tvalid;
	wire [dsps_pkg::M_DATA_W-1:0]  m_tdata;

	int gap_pct   = 10;
	int stall_pct = 86;
	int mismatches;
	int outstanding;
	int quiet_cycles = 0;
	int sent = 0;

	always #1 clk = ~clk;

	dual_stepper_pulse_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pulse_schedule_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("dual_stepper_pulse_scheduler: mismatch");
			$finish;
		end
	end

	task automatic send(input dsps_pkg::cmd_t cmd, input logic [15:0] steps_a,
			input logic [15:0] steps_b, input logic dir_a, input logic dir_b);
		logic taken;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= dsps_pkg::S_DATA_W'({$urandom, $urandom});
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'b0, dir_b, dir_a, steps_b, steps_a};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	task automatic tick_run(input int count);
		for (int k = 0; k < count; k++) begin
			send(dsps_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom),
				1'($urandom));
		end
	endtask

	// The command stream holds off until every queued result has been seen.
	task automatic drain();
		s_tvalid <= 1'b0;
		do begin
			@(negedge clk);
		end while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic random_move();
		logic [15:0] steps_a;
		logic [15:0] steps_b;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send(dsps_pkg::cmd_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
				1'($urandom), 1'($urandom));
		end else begin
			if (pick < 20) begin
				steps_a = 16'($urandom);
				steps_b = 16'($urandom);
			end else begin
				steps_a = 16'($urandom_range(9));
				steps_b = 16'($urandom_range(9));
			end
			send(dsps_pkg::CMD_LOAD, steps_a, steps_b, 1'($urandom), 1'($urandom));
			for (int k = $urandom_range(60, 1); k > 0; k--) begin
				if ($urandom_range(99) < 3) begin
					send($urandom_range(1) ? dsps_pkg::CMD_LIMIT_A : dsps_pkg::CMD_LIMIT_B,
						16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
				end else begin
					tick_run(1);
				end
			end
		end
	endtask

	initial begin
		int quota;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tick_run(2);
		send(dsps_pkg::CMD_LIMIT_A, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		send(dsps_pkg::CMD_LIMIT_B, 16'h0000, 16'h0000, 1'b0, 1'b0);
		send(dsps_pkg::CMD_LOAD, 16'd0, 16'd5, 1'b0, 1'b1);
		tick_run(2);
		send(dsps_pkg::CMD_LOAD, 16'd7, 16'd5, 1'b1, 1'b0);
		tick_run(4);
		send(dsps_pkg::CMD_LIMIT_A, 16'h0000, 16'h0000, 1'b0, 1'b0);
		tick_run(2);
		send(dsps_pkg::CMD_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		tick_run(2);
		send(dsps_pkg::CMD_LOAD, 16'hFFFF, 16'hFFFE, 1'b0, 1'b0);
		tick_run(2);
		send(dsps_pkg::CMD_LOAD, 16'hFFFF, 16'h0001, 1'b1, 1'b0);
		tick_run(2);
		send(dsps_pkg::CMD_LIMIT_B, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		send(dsps_pkg::CMD_LOAD, 16'd0, 16'd0, 1'b0, 1'b1);
		tick_run(2);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					gap_pct   = 10;
					stall_pct = 86;
				end
				1: begin
					gap_pct   = 86;
					stall_pct = 10;
				end
				default: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
			endcase
			quota = sent + PHASE_ITEMS;
			while (sent < quota) begin
				random_move();
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("dual_stepper_pulse_scheduler: match");
		end else begin
			$display("dual_stepper_pulse_scheduler: mismatch");
		end
		$finish;
	end

endmodule

>>> dual_stepper_pulse_scheduler.f
hw/rtl/dsps_pkg.sv
hw/rtl/dsps_sub.sv
hw/rtl/dsps_seq.sv
hw/rtl/dual_stepper_pulse_scheduler.sv
verif/pulse_schedule_monitor.sv
verif/testbench.sv
